// ----- rtl/mtep_pkg.sv -----
package mtep_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int DELTA_BITS  = 28;
  localparam int REM_BITS    = 8;
  localparam int DCNT_BITS   = 3;

  localparam logic [7:0] STATUS_BIT  = 8'h80;
  localparam logic [7:0] SYS_FIRST   = 8'hF0;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] SONG_POS    = 8'hF2;
  localparam logic [7:0] TIME_CODE   = 8'hF1;
  localparam logic [7:0] SONG_SEL    = 8'hF3;

  localparam logic [DCNT_BITS-1:0] DCNT_MAX      = '1;
  localparam logic [DCNT_BITS-1:0] DCNT_OVF_FROM = DCNT_BITS'(4);

  typedef enum logic [2:0] {
    PH_DELTA     = 3'd0,
    PH_EVENT     = 3'd1,
    PH_DATA      = 3'd2,
    PH_SYSEX     = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_META_LEN  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_DELTA_MORE = 3'd0,
    ROLE_DELTA_LAST = 3'd1,
    ROLE_STATUS     = 3'd2,
    ROLE_DATA       = 3'd3,
    ROLE_META_TYPE  = 3'd4,
    ROLE_META_LEN   = 3'd5,
    ROLE_SYSEX      = 3'd6
  } role_t;

  typedef struct packed {
    phase_t                 phase;
    logic [7:0]             running_status;
    logic [DELTA_BITS-1:0]  delta_accum;
    logic [DCNT_BITS-1:0]   delta_byte_count;
    logic [REM_BITS-1:0]    bytes_remaining;
    logic [LENGTH_BITS-1:0] length_count;
    logic [7:0]             meta_type_reg;
    logic [7:0]             cur_status;
  } parse_state_t;

  typedef struct packed {
    role_t                  byte_role;
    logic [7:0]             status_in_effect;
    logic [DELTA_BITS-1:0]  delta_ticks;
    logic                   delta_overflow;
    logic                   event_done;
    logic [LENGTH_BITS-1:0] event_length;
    logic [LENGTH_BITS-1:0] payload_index;
    logic [7:0]             meta_kind;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_DELTA,
    running_status:   8'h00,
    delta_accum:      '0,
    delta_byte_count: '0,
    bytes_remaining:  '0,
    length_count:     '0,
    meta_type_reg:    8'h00,
    cur_status:       8'h00
  };

  function automatic logic [REM_BITS-1:0] nibble_len(input logic [7:0] status);
    logic [REM_BITS-1:0] len;
    case (status[6:4])
      3'd4, 3'd5: len = REM_BITS'(1);
      3'd7:       len = '0;
      default:    len = REM_BITS'(2);
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/mtep_step.sv -----
module mtep_step
  import mtep_pkg::*;
(
  input  parse_state_t  state,
  input  logic [7:0]    track_byte,
  input  logic          restart,
  output parse_state_t  state_next,
  output parse_result_t result
);

  parse_state_t s;
  parse_state_t n;
  logic         done;
  logic         in_delta;
  role_t        role;
  logic [LENGTH_BITS-1:0] pidx;
  logic [LENGTH_BITS-1:0] lc_inc;

  assign s      = restart ? STATE_RESET : state;
  assign lc_inc = (s.length_count == '1) ? s.length_count
                                         : s.length_count + LENGTH_BITS'(1);

  always_comb begin
    n        = s;
    done     = 1'b0;
    in_delta = 1'b0;
    role     = ROLE_DELTA_MORE;
    pidx     = '0;
    case (s.phase)
      PH_EVENT: begin
        if ((track_byte & STATUS_BIT) != 8'h00) begin
          role = ROLE_STATUS;
          n.cur_status     = track_byte;
          n.running_status = (track_byte >= SYS_FIRST) ? 8'h00 : track_byte;
          if (track_byte == SYSEX_START) begin
            n.phase = PH_SYSEX;
          end else if (track_byte == META_STATUS) begin
            n.phase = PH_META_TYPE;
          end else begin
            if (track_byte == SONG_POS) begin
              n.bytes_remaining = REM_BITS'(2);
            end else if (track_byte == TIME_CODE || track_byte == SONG_SEL) begin
              n.bytes_remaining = REM_BITS'(1);
            end else begin
              n.bytes_remaining = nibble_len(track_byte);
            end
            if (n.bytes_remaining == '0) begin
              done = 1'b1;
            end else begin
              n.phase = PH_DATA;
            end
          end
        end else begin
          role = ROLE_DATA;
          n.cur_status   = s.running_status;
          n.length_count = lc_inc;
          if (nibble_len(s.running_status) <= REM_BITS'(1)) begin
            n.bytes_remaining = '0;
            done = 1'b1;
          end else begin
            n.bytes_remaining = nibble_len(s.running_status) - REM_BITS'(1);
            n.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        role = ROLE_DATA;
        pidx = s.length_count;
        n.length_count = lc_inc;
        if (s.bytes_remaining <= REM_BITS'(1)) begin
          n.bytes_remaining = '0;
          done = 1'b1;
        end else begin
          n.bytes_remaining = s.bytes_remaining - REM_BITS'(1);
        end
      end
      PH_SYSEX: begin
        role = ROLE_SYSEX;
        pidx = s.length_count;
        n.length_count = lc_inc;
        done = (track_byte == SYSEX_END);
      end
      PH_META_TYPE: begin
        role = ROLE_META_TYPE;
        pidx = s.length_count;
        n.meta_type_reg = track_byte;
        n.length_count  = lc_inc;
        n.phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        role = ROLE_META_LEN;
        pidx = s.length_count;
        n.length_count    = lc_inc;
        n.bytes_remaining = REM_BITS'(track_byte);
        if (track_byte == 8'h00) begin
          done = 1'b1;
        end else begin
          n.phase = PH_DATA;
        end
      end
      default: begin
        in_delta = 1'b1;
        if (s.delta_byte_count == '0) begin
          n.delta_accum   = '0;
          n.length_count  = '0;
          n.meta_type_reg = 8'h00;
          n.cur_status    = 8'h00;
        end
        n.delta_accum = {n.delta_accum[DELTA_BITS-8:0], track_byte[6:0]};
        if (s.delta_byte_count != DCNT_MAX) begin
          n.delta_byte_count = s.delta_byte_count + DCNT_BITS'(1);
        end
        if ((track_byte & STATUS_BIT) != 8'h00) begin
          role = ROLE_DELTA_MORE;
          n.phase = PH_DELTA;
        end else begin
          role = ROLE_DELTA_LAST;
          n.phase = PH_EVENT;
        end
      end
    endcase

    result.byte_role        = role;
    result.status_in_effect = in_delta ? 8'h00 : n.cur_status;
    result.delta_ticks      = n.delta_accum;
    result.delta_overflow   = (n.delta_byte_count > DCNT_OVF_FROM);
    result.event_done       = done;
    result.event_length     = in_delta ? '0 : n.length_count;
    result.payload_index    = pidx;
    result.meta_kind        = (!in_delta && n.cur_status == META_STATUS) ? n.meta_type_reg
                                                                         : 8'h00;

    state_next = n;
    if (done) begin
      state_next.phase            = PH_DELTA;
      state_next.delta_byte_count = '0;
      state_next.bytes_remaining  = '0;
    end
  end

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | track_byte, restart
// out      | out_valid / out_ready | byte_role, status_in_effect, delta_ticks,
//          |                       | delta_overflow, event_done, event_length,
//          |                       | payload_index, meta_kind
//
// One byte per cycle sustained while out_ready is high; each byte passes the input register, then the result register.
// The parser state register updates once per byte as it moves from the input
// register to the result register, which sets the one-byte-per-cycle rate.
// rst is synchronous: parser back to expecting delta, running status zero.
// A stalled result register holds the input register; both drain in order.
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             track_byte,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             byte_role,
  output logic [7:0]             status_in_effect,
  output logic [DELTA_BITS-1:0]  delta_ticks,
  output logic                   delta_overflow,
  output logic                   event_done,
  output logic [LENGTH_BITS-1:0] event_length,
  output logic [LENGTH_BITS-1:0] payload_index,
  output logic [7:0]             meta_kind
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_restart;
  parse_state_t  st;
  parse_state_t  st_next;
  parse_result_t res_next;
  parse_result_t res;
  logic          mv;

  assign mv       = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || mv;

  mtep_step u_step (
    .state      (st),
    .track_byte (s1_byte),
    .restart    (s1_restart),
    .state_next (st_next),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= STATE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (mv) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      s1_byte    <= track_byte;
      s1_restart <= restart;
    end
    if (mv) begin
      res <= res_next;
    end
  end

  assign byte_role        = res.byte_role;
  assign status_in_effect = res.status_in_effect;
  assign delta_ticks      = res.delta_ticks;
  assign delta_overflow   = res.delta_overflow;
  assign event_done       = res.event_done;
  assign event_length     = res.event_length;
  assign payload_index    = res.payload_index;
  assign meta_kind        = res.meta_kind;

  a_done_to_delta: assert property (@(posedge clk) disable iff (rst)
    (mv && res_next.event_done) |=> (st.phase == PH_DELTA))
    else $error("event end did not return parser to delta");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !mv) |=> (s1_valid && $stable(s1_byte) && $stable(s1_restart)))
    else $error("input register lost a stalled byte");

  a_delta_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (byte_role == ROLE_DELTA_MORE || byte_role == ROLE_DELTA_LAST))
    |-> (status_in_effect == 8'h00 && event_length == '0 && !event_done))
    else $error("delta byte reports event fields");

  a_meta_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (byte_role == ROLE_META_TYPE || byte_role == ROLE_META_LEN))
    |-> (status_in_effect == META_STATUS))
    else $error("meta byte outside a meta event");

endmodule

// ----- bench/tb_midi_track_event_parser.sv -----
module tb_midi_track_event_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam logic [7:0] DATA_COUNT [8] = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'd0};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             track_byte = 8'h00;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [2:0]             byte_role;
  logic [7:0]             status_in_effect;
  logic [DELTA_BITS-1:0]  delta_ticks;
  logic                   delta_overflow;
  logic                   event_done;
  logic [LENGTH_BITS-1:0] event_length;
  logic [LENGTH_BITS-1:0] payload_index;
  logic [7:0]             meta_kind;

  midi_track_event_parser u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .track_byte       (track_byte),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .byte_role        (byte_role),
    .status_in_effect (status_in_effect),
    .delta_ticks      (delta_ticks),
    .delta_overflow   (delta_overflow),
    .event_done       (event_done),
    .event_length     (event_length),
    .payload_index    (payload_index),
    .meta_kind        (meta_kind)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  parse_result_t pending_results[$];

  phase_t                 ph        = PH_DELTA;
  logic [7:0]             run_stat  = 8'h00;
  logic [DELTA_BITS-1:0]  acc       = '0;
  logic [2:0]             dcount    = '0;
  logic [7:0]             remain    = '0;
  logic [LENGTH_BITS-1:0] len_count = '0;
  logic [7:0]             meta_t    = 8'h00;
  logic [7:0]             cur_stat  = 8'h00;

  logic [7:0] last_chan = 8'h00;

  function automatic void clear_parser();
    ph        = PH_DELTA;
    run_stat  = 8'h00;
    acc       = '0;
    dcount    = '0;
    remain    = '0;
    len_count = '0;
    meta_t    = 8'h00;
    cur_stat  = 8'h00;
  endfunction

  function automatic void bump_length();
    if (len_count != '1) len_count++;
  endfunction

  function automatic parse_result_t predict_byte_result(input logic [7:0] b, input logic rs);
    parse_result_t          r;
    logic [LENGTH_BITS-1:0] pidx;
    logic                   done;
    logic                   in_delta;
    r        = '0;
    pidx     = '0;
    done     = 1'b0;
    in_delta = 1'b0;
    if (rs) clear_parser();
    case (ph)
      PH_EVENT: begin
        if (b[7]) begin
          r.byte_role = ROLE_STATUS;
          cur_stat = b;
          run_stat = (b >= SYS_FIRST) ? 8'h00 : b;
          if (b == SYSEX_START) begin
            ph = PH_SYSEX;
          end else if (b == META_STATUS) begin
            ph = PH_META_TYPE;
          end else begin
            if (b == SONG_POS) remain = 8'd2;
            else if (b == TIME_CODE || b == SONG_SEL) remain = 8'd1;
            else remain = DATA_COUNT[b[6:4]];
            if (remain == 0) done = 1'b1;
            else ph = PH_DATA;
          end
        end else begin
          r.byte_role = ROLE_DATA;
          cur_stat = run_stat;
          remain = DATA_COUNT[cur_stat[6:4]];
          bump_length();
          if (remain <= 1) begin
            remain = '0;
            done = 1'b1;
          end else begin
            remain--;
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        r.byte_role = ROLE_DATA;
        pidx = len_count;
        bump_length();
        if (remain <= 1) begin
          remain = '0;
          done = 1'b1;
        end else begin
          remain--;
        end
      end
      PH_SYSEX: begin
        r.byte_role = ROLE_SYSEX;
        pidx = len_count;
        bump_length();
        if (b == SYSEX_END) done = 1'b1;
      end
      PH_META_TYPE: begin
        r.byte_role = ROLE_META_TYPE;
        pidx = len_count;
        meta_t = b;
        bump_length();
        ph = PH_META_LEN;
      end
      PH_META_LEN: begin
        r.byte_role = ROLE_META_LEN;
        pidx = len_count;
        bump_length();
        remain = b;
        if (b == 0) done = 1'b1;
        else ph = PH_DATA;
      end
      default: begin
        in_delta = 1'b1;
        if (dcount == 0) begin
          acc       = '0;
          len_count = '0;
          meta_t    = 8'h00;
          cur_stat  = 8'h00;
        end
        acc = {acc[DELTA_BITS-8:0], b[6:0]};
        if (dcount != 3'd7) dcount++;
        if (b[7]) begin
          r.byte_role = ROLE_DELTA_MORE;
          ph = PH_DELTA;
        end else begin
          r.byte_role = ROLE_DELTA_LAST;
          ph = PH_EVENT;
        end
      end
    endcase
    r.status_in_effect = in_delta ? 8'h00 : cur_stat;
    r.delta_ticks      = acc;
    r.delta_overflow   = (dcount > 3'd4);
    r.event_done       = done;
    r.event_length     = in_delta ? '0 : len_count;
    r.payload_index    = pidx;
    r.meta_kind        = (!in_delta && cur_stat == META_STATUS) ? meta_t : 8'h00;
    if (done) begin
      ph     = PH_DELTA;
      dcount = '0;
      remain = '0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    parse_result_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no expected result pending");
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("byte_role", 32'(exp_r.byte_role), 32'(byte_role));
          check_field("status_in_effect", 32'(exp_r.status_in_effect), 32'(status_in_effect));
          check_field("delta_ticks", 32'(exp_r.delta_ticks), 32'(delta_ticks));
          check_field("delta_overflow", 32'(exp_r.delta_overflow), 32'(delta_overflow));
          check_field("event_done", 32'(exp_r.event_done), 32'(event_done));
          check_field("event_length", 32'(exp_r.event_length), 32'(event_length));
          check_field("payload_index", 32'(exp_r.payload_index), 32'(payload_index));
          check_field("meta_kind", 32'(exp_r.meta_kind), 32'(meta_kind));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_byte_result(track_byte, restart));
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid   <= 1'b1;
    track_byte <= b;
    restart    <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic test_data_without_status();
    send_byte(8'h00, 1'b1);
    send_byte(8'h12);
    send_byte(8'h34);
  endtask

  task automatic test_channel_running_status();
    send_byte(8'h00);
    send_byte(8'h93);
    send_byte(8'h3C);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h00);
  endtask

  task automatic test_long_delta();
    repeat (5) send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hC5);
    send_byte(8'h01);
  endtask

  task automatic test_system_events();
    send_byte(8'h00);
    send_byte(SYSEX_START);
    send_byte(SYSEX_END);
    send_byte(8'h00);
    send_byte(SONG_POS);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hF6);
    send_byte(8'h00);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(META_STATUS);
    send_byte(8'h2F);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(META_STATUS);
    send_byte(8'h51);
    send_byte(8'h01);
    send_byte(8'hA1);
  endtask

  task automatic test_restart_mid_event();
    send_byte(8'h00);
    send_byte(8'h90);
    send_byte(8'h00, 1'b1);
    send_byte(8'h22);
  endtask

  task automatic send_event(input bit fresh);
    int         n;
    int         kind;
    logic [7:0] st;
    logic [7:0] b;
    int         cnt;
    if (fresh) last_chan = 8'h00;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 127));
      if (i < n - 1) b[7] = 1'b1;
      send_byte(b, fresh && i == 0);
    end
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      if ($urandom_range(0, 99) < 35) begin
        cnt = DATA_COUNT[last_chan[6:4]];
      end else begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        send_byte(st);
        last_chan = st;
        cnt = DATA_COUNT[st[6:4]];
      end
      for (int i = 0; i < cnt; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(8'($urandom_range(0, 127)));
      end
    end else if (kind < 60) begin
      send_byte(SYSEX_START);
      cnt = $urandom_range(0, 8);
      for (int i = 0; i < cnt; i++) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYSEX_END) b = 8'h00;
        send_byte(b);
      end
      send_byte(SYSEX_END);
      last_chan = 8'h00;
    end else if (kind < 80) begin
      send_byte(META_STATUS);
      send_byte(8'($urandom_range(0, 255)));
      cnt = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 5);
      send_byte(8'(cnt));
      for (int i = 0; i < cnt; i++) send_byte(8'($urandom_range(0, 255)));
      last_chan = 8'h00;
    end else begin
      st = 8'($urandom_range(8'hF1, 8'hFE));
      send_byte(st);
      if (st == SONG_POS) cnt = 2;
      else if (st == TIME_CODE || st == SONG_SEL) cnt = 1;
      else cnt = 0;
      for (int i = 0; i < cnt; i++) send_byte(8'($urandom_range(0, 255)));
      last_chan = 8'h00;
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_bytes);
    int stop_at;
    bit fresh;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at        = bytes_sent + n_bytes;
    fresh          = 1'b1;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise();
        fresh = 1'b1;
      end else begin
        send_event(fresh || $urandom_range(0, 49) == 0);
        fresh = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_data_without_status();
    test_channel_running_status();
    test_long_delta();
    test_system_events();
    test_restart_mid_event();
    test_random_traffic(0, 0, 360);
    test_random_traffic(82, 0, 360);
    test_random_traffic(0, 82, 360);
    test_random_traffic(38, 38, 360);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
